/* design/inverted_index_overlap_score_assert.svh */
// Assertion macros shared by the scorer modules.
`ifndef INVERTED_INDEX_OVERLAP_SCORE_ASSERT_SVH
`define INVERTED_INDEX_OVERLAP_SCORE_ASSERT_SVH

// Plain property, checked every clock outside reset.
`define IIOS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same check, also checked while reset is high.
`define IIOS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* design/iios_pkg.sv */
// Shared types, codes and defaults of the overlap scorer.
package iios_pkg;

   localparam int MAX_FRAMES_DEF  = 64;
   localparam int MAX_ENTRIES_DEF = 4096;
   localparam int WORD_BITS_DEF   = 16;

   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_END    = 3'd1;
   localparam logic [2:0] ACT_CLEAR  = 3'd2;
   localparam logic [2:0] ACT_QUERY  = 3'd3;
   localparam logic [2:0] ACT_READ   = 3'd4;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_FRAME_FULL  = 2'd1;
   localparam logic [1:0] ST_ENTRY_FULL  = 2'd2;
   localparam logic [1:0] ST_BAD_INDEX   = 2'd3;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_END,
      OP_CLEAR,
      OP_QUERY,
      OP_READ,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [15:0]        word;
      logic signed [15:0] weight;
      logic [5:0]         fidx;
   } cmd_type;

   // queue head towards the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   // back end control towards the front end
   typedef struct packed {
      logic pop;
      logic init;
   } back_stat_type;

endpackage

/* design/inverted_index_overlap_score.sv */
// Top level of the inverted-index overlap scorer.
// Usage:
//  - A request transaction is taken at a rising edge with start high and busy low.
//    Fields: req_action (insert, end keyframe, clear, query, read), req_word,
//    req_weight (signed Q3.12) and req_frame_index.
//  - Every request gives exactly one response: rsp_valid is high for one cycle
//    with rsp_score, rsp_frames_stored and rsp_status. The receiver cannot stall.
//  - Requests pass through a two-deep queue; busy rises when it is full, so up to
//    two requests may wait while the back end works.
//  - The back end handles one request at a time after it leaves the queue; a
//    query walks the entry store one entry at a time and does a read-modify-write
//    of the score table for each entry of a closed keyframe that matches the
//    word. The response is registered.
//  - After reset the score table is swept to zero; busy stays high during that
//    sweep. Counts reset to zero; the entry store is not cleared.
//  - Scores saturate at 2^32-1 and keep accumulating until a clear.
module inverted_index_overlap_score #(
   parameter int MAX_FRAMES  = iios_pkg::MAX_FRAMES_DEF,
   parameter int MAX_ENTRIES = iios_pkg::MAX_ENTRIES_DEF,
   parameter int WORD_BITS   = iios_pkg::WORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [15:0]        req_word,
   input  logic signed [15:0] req_weight,
   input  logic [5:0]         req_frame_index,
   output logic               rsp_valid,
   output logic [31:0]        rsp_score,
   output logic [6:0]         rsp_frames_stored,
   output logic [1:0]         rsp_status
);
   import iios_pkg::*;

   head_type      head;
   back_stat_type back_stat;

   // decode and queue
   iios_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_word        (req_word),
      .req_weight      (req_weight),
      .req_frame_index (req_frame_index),
      .back_stat       (back_stat),
      .head            (head)
   );

   // stores and sequencer
   iios_back #(
      .MAX_FRAMES  (MAX_FRAMES),
      .MAX_ENTRIES (MAX_ENTRIES),
      .WORD_BITS   (WORD_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .back_stat         (back_stat),
      .rsp_valid         (rsp_valid),
      .rsp_score         (rsp_score),
      .rsp_frames_stored (rsp_frames_stored),
      .rsp_status        (rsp_status)
   );

endmodule

/* design/iios_front.sv */
// Front end: accepts transactions, decodes them and queues them for the back end.
module iios_front #(
   parameter int WORD_BITS = iios_pkg::WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_action,
   input  logic [15:0]           req_word,
   input  logic signed [15:0]    req_weight,
   input  logic [5:0]            req_frame_index,
   input  iios_pkg::back_stat_type back_stat,
   output iios_pkg::head_type    head
);
   import iios_pkg::*;

   localparam logic [15:0] WordMask = (WORD_BITS >= 16) ? 16'hFFFF
                                      : 16'((32'd1 << WORD_BITS) - 32'd1);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    dec;

   always_comb begin
      unique case (req_action)
         ACT_INSERT: dec.op = OP_INSERT;
         ACT_END:    dec.op = OP_END;
         ACT_CLEAR:  dec.op = OP_CLEAR;
         ACT_QUERY:  dec.op = OP_QUERY;
         ACT_READ:   dec.op = OP_READ;
         default:    dec.op = OP_NONE;
      endcase
      dec.word   = req_word & WordMask;
      dec.weight = req_weight;
      dec.fidx   = req_frame_index;
   end

   assign busy = (cnt_ff == 2'd2) || back_stat.init;
   assign push = start && !busy;

   assign head.valid = (cnt_ff != 2'd0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ back_stat.pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, back_stat.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

   `include "inverted_index_overlap_score_assert.svh"

   `IIOS_ASSERT(a_no_pop_empty, back_stat.pop |-> head.valid, "pop from empty queue")
   `IIOS_ASSERT(a_cnt_range, cnt_ff != 2'd3, "queue count out of range")
   `IIOS_ASSERT(a_push_room, push |-> (cnt_ff != 2'd2), "push into full queue")

endmodule

/* design/iios_back.sv */
// Back end: entry store, score table and the command sequencer.
module iios_back #(
   parameter int MAX_FRAMES  = iios_pkg::MAX_FRAMES_DEF,
   parameter int MAX_ENTRIES = iios_pkg::MAX_ENTRIES_DEF,
   parameter int WORD_BITS   = iios_pkg::WORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  iios_pkg::head_type      head,
   output iios_pkg::back_stat_type back_stat,
   output logic                    rsp_valid,
   output logic [31:0]             rsp_score,
   output logic [6:0]              rsp_frames_stored,
   output logic [1:0]              rsp_status
);
   import iios_pkg::*;

   localparam int WB  = (WORD_BITS < 16) ? WORD_BITS : 16;
   localparam int FAB = $clog2(MAX_FRAMES);
   localparam int FCB = $clog2(MAX_FRAMES + 1);
   localparam int EAB = $clog2(MAX_ENTRIES);
   localparam int ECB = $clog2(MAX_ENTRIES + 1);
   localparam int FW  = (FCB > 6) ? FCB : 6;
   localparam int EW  = WB + FAB + 16;
   localparam logic [FCB-1:0] FrameMax = FCB'(MAX_FRAMES);
   localparam logic [ECB-1:0] EntryMax = ECB'(MAX_ENTRIES);
   localparam logic [FAB-1:0] FrameLast = FAB'(MAX_FRAMES - 1);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_CLR, S_QRD, S_QENT, S_QADD, S_RD
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [ECB-1:0]     entry_count_ff, entry_count_in;
   logic [FCB-1:0]     frame_count_ff, frame_count_in;
   logic [ECB-1:0]     walk_ff, walk_in;
   logic [FAB-1:0]     clr_ff, clr_in;
   logic [18:0]        term_ff, term_in;
   logic [FAB-1:0]     hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_score_ff, rsp_score_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic [EW-1:0]      ent_mem [MAX_ENTRIES];
   logic [EW-1:0]      ent_rd_ff;
   logic               ent_we;
   logic [EW-1:0]      ent_wdata;
   logic [31:0]        sc_mem [MAX_FRAMES];
   logic [31:0]        sc_rd_ff;
   logic               sc_we;
   logic [FAB-1:0]     sc_waddr, sc_raddr;
   logic [31:0]        sc_wdata;

   logic [WB-1:0]      e_word;
   logic [FAB-1:0]     e_frame;
   logic signed [15:0] e_weight;
   logic [FW-1:0]      fidx_ext;
   logic               hit;
   logic signed [19:0] q_x, v_x, d_x, ad_x, t_x;
   logic [32:0]        sum;

   assign {e_word, e_frame, e_weight} = ent_rd_ff;
   assign fidx_ext = FW'(cmd_ff.fidx);
   assign hit = (e_word == cmd_ff.word[WB-1:0])
                && ({1'b0, e_frame} < FCB'(frame_count_ff));

   // |(|q - v| - q - v)|
   always_comb begin
      q_x  = 20'(cmd_ff.weight);
      v_x  = 20'(e_weight);
      d_x  = q_x - v_x;
      ad_x = d_x[19] ? -d_x : d_x;
      t_x  = ad_x - q_x - v_x;
      t_x  = t_x[19] ? -t_x : t_x;
   end

   assign sum = {1'b0, sc_rd_ff} + 33'(term_ff);

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      entry_count_in = entry_count_ff;
      frame_count_in = frame_count_ff;
      walk_in        = walk_ff;
      clr_in         = clr_ff;
      term_in        = term_ff;
      hit_in         = hit_ff;
      rsp_valid_in   = 1'b0;
      rsp_score_in   = 32'd0;
      rsp_status_in  = ST_OK;
      ent_we         = 1'b0;
      ent_wdata      = {head.cmd.word[WB-1:0], frame_count_ff[FAB-1:0], head.cmd.weight};
      sc_we          = 1'b0;
      sc_waddr       = clr_ff;
      sc_wdata       = 32'd0;
      sc_raddr       = e_frame;
      back_stat.pop  = 1'b0;
      back_stat.init = (state_ff == S_INIT);

      unique case (state_ff)
         S_INIT: begin
            sc_we = 1'b1;
            if (clr_ff == FrameLast) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (head.valid) begin
               back_stat.pop = 1'b1;
               cmd_in        = head.cmd;
               unique case (head.cmd.op)
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (frame_count_ff >= FrameMax) begin
                        rsp_status_in = ST_FRAME_FULL;
                     end else if (entry_count_ff >= EntryMax) begin
                        rsp_status_in = ST_ENTRY_FULL;
                     end else begin
                        ent_we         = 1'b1;
                        entry_count_in = entry_count_ff + 1'b1;
                     end
                  end
                  OP_END: begin
                     rsp_valid_in = 1'b1;
                     if (frame_count_ff >= FrameMax) begin
                        rsp_status_in = ST_FRAME_FULL;
                     end else begin
                        frame_count_in = frame_count_ff + 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLR;
                  end
                  OP_QUERY: begin
                     walk_in  = '0;
                     state_in = S_QRD;
                  end
                  OP_READ: begin
                     if (FW'(head.cmd.fidx) < FW'(frame_count_ff)) begin
                        sc_raddr = FAB'(FW'(head.cmd.fidx));
                        state_in = S_RD;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_INDEX;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_CLR: begin
            sc_we = 1'b1;
            if (clr_ff == FrameLast) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_QRD: begin
            if (walk_ff == entry_count_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_QENT;
            end
         end
         S_QENT: begin
            term_in  = 19'(t_x);
            hit_in   = e_frame;
            walk_in  = walk_ff + 1'b1;
            state_in = hit ? S_QADD : S_QRD;
         end
         S_QADD: begin
            sc_we    = 1'b1;
            sc_waddr = hit_ff;
            sc_wdata = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            state_in = S_QRD;
         end
         S_RD: begin
            rsp_valid_in = 1'b1;
            rsp_score_in = sc_rd_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         entry_count_ff <= '0;
         frame_count_ff <= '0;
         walk_ff        <= '0;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         frame_count_ff <= frame_count_in;
         walk_ff        <= walk_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      term_ff       <= term_in;
      hit_ff        <= hit_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[entry_count_ff[EAB-1:0]] <= ent_wdata;
      end
      ent_rd_ff <= ent_mem[walk_ff[EAB-1:0]];
   end

   always_ff @(posedge clock) begin
      if (sc_we) begin
         sc_mem[sc_waddr] <= sc_wdata;
      end
      sc_rd_ff <= sc_mem[sc_raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_score         = rsp_score_ff;
   assign rsp_frames_stored = 7'(frame_count_ff);
   assign rsp_status        = rsp_status_ff;

   `include "inverted_index_overlap_score_assert.svh"

   `IIOS_ASSERT(a_entry_bound, entry_count_ff <= EntryMax, "entry count past store size")
   `IIOS_ASSERT(a_frame_bound, frame_count_ff <= FrameMax, "frame count past store size")
   `IIOS_ASSERT(a_walk_bound, walk_ff <= entry_count_ff || state_ff == S_IDLE || state_ff == S_INIT || state_ff == S_CLR || state_ff == S_RD, "walk past last entry")
   `IIOS_ASSERT_ALWAYS(a_no_rsp_init, (state_ff == S_INIT) |-> !rsp_valid_ff, "response during init sweep")

endmodule
